/* design/bobs_pkg.sv */
`default_nettype none

package bobs_pkg;

   localparam int MAX_PROBES  = 16;
   localparam int SLOT_BITS   = $clog2(MAX_PROBES);
   localparam int COUNT_BITS  = $clog2(MAX_PROBES + 1);
   localparam int FIELD_BITS  = 16;
   localparam int COORD_BITS  = 16;
   localparam int CORNER_BITS = 3 * COORD_BITS;
   localparam int ID_BITS     = 8;
   localparam int VOL_BITS    = 48;
   localparam int CSR_BITS    = 5;
   localparam int ENTRY_BITS  = 2 * CORNER_BITS + ID_BITS;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // travels alongside each table read
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic                hit;
      logic [ID_BITS-1:0]  id;
      logic [VOL_BITS-1:0] vol;
   } eval_type;

endpackage

`default_nettype wire

/* design/bobs_req_if.sv */
`default_nettype none

interface bobs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic [3:0]                           slot;
   logic signed [bobs_pkg::FIELD_BITS-1:0] min_x;
   logic signed [bobs_pkg::FIELD_BITS-1:0] min_y;
   logic signed [bobs_pkg::FIELD_BITS-1:0] min_z;
   logic signed [bobs_pkg::FIELD_BITS-1:0] max_x;
   logic signed [bobs_pkg::FIELD_BITS-1:0] max_y;
   logic signed [bobs_pkg::FIELD_BITS-1:0] max_z;
   logic [bobs_pkg::ID_BITS-1:0]         probe_id;

   modport source (output valid, action, slot, min_x, min_y, min_z, max_x, max_y, max_z,
                   probe_id, input ready);
   modport sink (input valid, action, slot, min_x, min_y, min_z, max_x, max_y, max_z,
                 probe_id, output ready);
endinterface

`default_nettype wire

/* design/bobs_rsp_if.sv */
`default_nettype none

interface bobs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic                          keep_previous;
   logic [bobs_pkg::ID_BITS-1:0]  best_id;
   logic [bobs_pkg::VOL_BITS-1:0] best_volume;

   modport source (output valid, found, keep_previous, best_id, best_volume, input ready);
   modport sink (input valid, found, keep_previous, best_id, best_volume, output ready);
endinterface

`default_nettype wire

/* design/bobs_ram.sv */
`default_nettype none

module bobs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/bobs_eval.sv */
`default_nettype none

// Overlap test, extents and volume for one table entry per cycle.
// Stages: read align, extents, x*y product, (x*y)*z product.
module bobs_eval (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bobs_pkg::tag_type                rd_tag,
   input  wire logic [bobs_pkg::ENTRY_BITS-1:0]  rd_data,
   input  wire logic [bobs_pkg::CORNER_BITS-1:0] mesh_lo,
   input  wire logic [bobs_pkg::CORNER_BITS-1:0] mesh_hi,
   output      bobs_pkg::eval_type               ev
);

   localparam int C = bobs_pkg::COORD_BITS;

   bobs_pkg::tag_type tag0_ff, tag1_ff, tag2_ff;
   logic              hit1_ff, hit2_ff;
   logic [bobs_pkg::ID_BITS-1:0] id1_ff, id2_ff;
   logic [C-1:0]      ext1_ff [3];
   logic [C-1:0]      ext_z2_ff;
   logic [2*C-1:0]    p01_ff;
   bobs_pkg::eval_type ev_ff;

   logic signed [C-1:0] blo [3];
   logic signed [C-1:0] bhi [3];
   logic signed [C-1:0] mlo [3];
   logic signed [C-1:0] mhi [3];
   logic signed [C-1:0] ilo [3];
   logic signed [C-1:0] ihi [3];
   logic [C:0]          diff [3];
   logic [C-1:0]        ext_in [3];
   logic [2:0]          hit_axis;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         blo[a] = rd_data[a*C +: C];
         bhi[a] = rd_data[bobs_pkg::CORNER_BITS + a*C +: C];
         mlo[a] = mesh_lo[a*C +: C];
         mhi[a] = mesh_hi[a*C +: C];
         ilo[a] = (blo[a] > mlo[a]) ? blo[a] : mlo[a];
         ihi[a] = (bhi[a] < mhi[a]) ? bhi[a] : mhi[a];
         diff[a] = {ihi[a][C-1], ihi[a]} - {ilo[a][C-1], ilo[a]};
         // negative extent means an inverted box: no overlap
         hit_axis[a] = (mhi[a] >= blo[a]) && (bhi[a] >= mlo[a]) && !diff[a][C];
         ext_in[a] = (diff[a] == '0) ? C'(1) : diff[a][C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         tag2_ff <= '0;
         ev_ff.valid <= 1'b0;
         ev_ff.last <= 1'b0;
      end else begin
         tag0_ff <= rd_tag;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         ev_ff.valid <= tag2_ff.valid;
         ev_ff.last <= tag2_ff.last;
      end
      hit1_ff <= &hit_axis;
      id1_ff <= rd_data[bobs_pkg::ENTRY_BITS-1 -: bobs_pkg::ID_BITS];
      for (int a = 0; a < 3; a++) begin
         ext1_ff[a] <= ext_in[a];
      end
      hit2_ff <= hit1_ff;
      id2_ff <= id1_ff;
      ext_z2_ff <= ext1_ff[2];
      p01_ff <= (2*C)'(ext1_ff[0]) * (2*C)'(ext1_ff[1]);
      ev_ff.hit <= hit2_ff;
      ev_ff.id <= id2_ff;
      ev_ff.vol <= bobs_pkg::VOL_BITS'((3*C)'(p01_ff) * (3*C)'(ext_z2_ff));
   end

   assign ev = ev_ff;

endmodule

`default_nettype wire

/* design/best_overlap_box_select.sv */
// Probe box table with best-overlap query.
//
// req_chan carries transactions of two kinds. A load (action 0) writes a probe
// box and its id into table slot `slot`. A query (action 1)
// carries a mesh box and yields one rsp_chan transaction: the id and volume of
// the probe with the largest intersection volume (lowest slot wins a tie),
// found = 0 when nothing overlaps, keep_previous = 1 when the slot count is one.
// csr_wr_en / csr_wr_data set the number of valid slots; write only when idle.
//
// A query over n >= 2 slots reads the table one slot per cycle through a
// single RAM read port into a four-stage evaluate pipeline; the walk, drain
// and output states follow, and the next transaction is taken once the block
// is back in idle. With fewer than two slots the query goes straight from
// idle to the output state. One query is in flight at a time.
// The response sits in an output register; a new transaction is taken while it
// waits, but a second query result holds until rsp_chan drains.
// Reset (synchronous) clears the slot count and all control; table contents
// are undefined until loaded.
`default_nettype none

module best_overlap_box_select (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bobs_req_if.sink                            req_chan,
   bobs_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_wr_en,
   input  wire logic [bobs_pkg::CSR_BITS-1:0]  csr_wr_data
);

   localparam int CB = bobs_pkg::COUNT_BITS;
   localparam int C  = bobs_pkg::COORD_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [bobs_pkg::CSR_BITS-1:0]    probe_count_ff;
   logic [CB-1:0]                    count_sat;
   logic [bobs_pkg::SLOT_BITS-1:0]   walk_idx_ff, walk_idx_in;
   logic                             walk_last;
   logic [bobs_pkg::CORNER_BITS-1:0] mesh_lo_ff, mesh_hi_ff;
   logic                             best_found_ff, keep_ff;
   logic [bobs_pkg::ID_BITS-1:0]     best_id_ff;
   logic [bobs_pkg::VOL_BITS-1:0]    best_vol_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_keep_ff;
   logic [bobs_pkg::ID_BITS-1:0]     rsp_id_ff;
   logic [bobs_pkg::VOL_BITS-1:0]    rsp_vol_ff;

   logic accept, is_query, ram_wr_en, out_load, best_take;
   logic [bobs_pkg::ENTRY_BITS-1:0] ram_wr_data, ram_rd_data;
   bobs_pkg::tag_type  rd_tag;
   bobs_pkg::eval_type ev;

   assign count_sat = (CB'(probe_count_ff) > CB'(bobs_pkg::MAX_PROBES)) ?
                      CB'(bobs_pkg::MAX_PROBES) : CB'(probe_count_ff);
   assign walk_last = (CB'(walk_idx_ff) == count_sat - CB'(1));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign is_query = (req_chan.action == bobs_pkg::ACT_QUERY);
   assign ram_wr_en = accept && (req_chan.action == bobs_pkg::ACT_LOAD) &&
                      (32'(req_chan.slot) < bobs_pkg::MAX_PROBES);
   assign ram_wr_data = {req_chan.probe_id,
                         req_chan.max_z[C-1:0], req_chan.max_y[C-1:0], req_chan.max_x[C-1:0],
                         req_chan.min_z[C-1:0], req_chan.min_y[C-1:0], req_chan.min_x[C-1:0]};

   assign rd_tag.valid = (state_ff == ST_WALK);
   assign rd_tag.last = walk_last;

   bobs_ram #(
      .WIDTH(bobs_pkg::ENTRY_BITS),
      .DEPTH(bobs_pkg::MAX_PROBES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_chan.slot[bobs_pkg::SLOT_BITS-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (rd_tag.valid),
      .rd_addr (walk_idx_ff),
      .rd_data (ram_rd_data)
   );

   bobs_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .rd_tag  (rd_tag),
      .rd_data (ram_rd_data),
      .mesh_lo (mesh_lo_ff),
      .mesh_hi (mesh_hi_ff),
      .ev      (ev)
   );

   assign best_take = ev.valid && ev.hit && (!best_found_ff || (ev.vol > best_vol_ff));
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      walk_idx_in = walk_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            walk_idx_in = '0;
            if (accept && is_query) begin
               state_in = (count_sat < CB'(2)) ? ST_OUT : ST_WALK;
            end
         end
         ST_WALK: begin
            walk_idx_in = walk_idx_ff + 1'b1;
            if (walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (ev.valid && ev.last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_idx_ff <= '0;
         probe_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_idx_ff <= walk_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            probe_count_ff <= csr_wr_data;
         end
         if (accept && is_query) begin
            best_found_ff <= 1'b0;
         end else if (best_take) begin
            best_found_ff <= 1'b1;
         end
      end

      if (accept && is_query) begin
         mesh_lo_ff <= {req_chan.min_z[C-1:0], req_chan.min_y[C-1:0], req_chan.min_x[C-1:0]};
         mesh_hi_ff <= {req_chan.max_z[C-1:0], req_chan.max_y[C-1:0], req_chan.max_x[C-1:0]};
         keep_ff <= (count_sat == CB'(1));
         best_id_ff <= '0;
         best_vol_ff <= '0;
      end else if (best_take) begin
         best_id_ff <= ev.id;
         best_vol_ff <= ev.vol;
      end

      if (out_load) begin
         rsp_found_ff <= best_found_ff;
         rsp_keep_ff <= keep_ff;
         rsp_id_ff <= best_id_ff;
         rsp_vol_ff <= best_vol_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.found = rsp_found_ff;
   assign rsp_chan.keep_previous = rsp_keep_ff;
   assign rsp_chan.best_id = rsp_id_ff;
   assign rsp_chan.best_volume = rsp_vol_ff;

   a_no_eval_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !ev.valid)
      else $error("evaluate pipeline busy while input is open");

   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      ev.valid && ev.last |-> state_ff == ST_DRAIN)
      else $error("last table entry evaluated outside drain");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> CB'(walk_idx_ff) < count_sat)
      else $error("table walk beyond slot count");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_chan.ready |=> state_ff == ST_OUT)
      else $error("result overwrote a pending response");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 600_000;
   localparam int DRAIN_CYCLES = 30;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 1600;

   typedef struct packed {
      logic                                        action;
      logic [bobs_pkg::SLOT_BITS-1:0]              slot;
      logic [2:0][bobs_pkg::FIELD_BITS-1:0]        lo;   // index 0 is x
      logic [2:0][bobs_pkg::FIELD_BITS-1:0]        hi;
      logic [bobs_pkg::ID_BITS-1:0]                probe_id;
   } box_cmd_type;

   typedef struct packed {
      logic                          found;
      logic                          keep_previous;
      logic [bobs_pkg::ID_BITS-1:0]  best_id;
      logic [bobs_pkg::VOL_BITS-1:0] best_volume;
   } probe_pick_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [bobs_pkg::CSR_BITS-1:0] csr_wr_data;

   bobs_req_if req_bus ();
   bobs_rsp_if rsp_bus ();

   best_overlap_box_select dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // shadow of the probe table and slot count
   logic [2:0][bobs_pkg::COORD_BITS-1:0] probe_lo [bobs_pkg::MAX_PROBES];
   logic [2:0][bobs_pkg::COORD_BITS-1:0] probe_hi [bobs_pkg::MAX_PROBES];
   logic [bobs_pkg::ID_BITS-1:0]         probe_tag [bobs_pkg::MAX_PROBES];
   int                                   probe_count_model;

   box_cmd_type    pending_cmds[$];
   probe_pick_type expected_picks[$];

   int  cmds_offered;
   int  cmds_accepted;
   int  errors;
   int  cycle_count;
   bit  idle_on;
   int  req_gap_left;
   int  rsp_stall_left;
   int  long_hold_left;
   int  long_holds_asked;
   int  long_holds_served;

   box_cmd_type    taken;
   probe_pick_type want;

   function automatic probe_pick_type pick_best_probe(box_cmd_type q);
      probe_pick_type r;
      int n, i, a;
      bit hit;
      logic signed [bobs_pkg::COORD_BITS-1:0] mlo, mhi, blo, bhi, ilo, ihi;
      logic [63:0] ext, vol;
      r = '0;
      n = (probe_count_model > bobs_pkg::MAX_PROBES) ? bobs_pkg::MAX_PROBES :
          probe_count_model;
      if (n == 1) begin
         r.keep_previous = 1'b1;
         return r;
      end
      for (i = 0; i < n; i++) begin
         hit = 1'b1;
         vol = 64'd1;
         for (a = 0; a < 3 && hit; a++) begin
            mlo = q.lo[a];
            mhi = q.hi[a];
            blo = probe_lo[i][a];
            bhi = probe_hi[i][a];
            if (!(mhi >= blo && bhi >= mlo)) begin
               hit = 1'b0;
            end else begin
               ilo = (blo > mlo) ? blo : mlo;
               ihi = (bhi < mhi) ? bhi : mhi;
               // an inverted box can pass the corner test yet leave no overlap
               if (ihi < ilo) begin
                  hit = 1'b0;
               end else begin
                  ext = 64'(int'(ihi) - int'(ilo));
                  if (ext == 0) ext = 64'd1;
                  vol = vol * ext;
               end
            end
         end
         if (hit) begin
            if ((vol >> bobs_pkg::VOL_BITS) != 0) vol = (64'd1 << bobs_pkg::VOL_BITS) - 1;
            if (!r.found || vol[bobs_pkg::VOL_BITS-1:0] > r.best_volume) begin
               r.found = 1'b1;
               r.best_volume = vol[bobs_pkg::VOL_BITS-1:0];
               r.best_id = probe_tag[i];
            end
         end
      end
      return r;
   endfunction

   function automatic int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic box_cmd_type mk_cmd(logic action, int slot, int x0, int y0, int z0,
                                          int x1, int y1, int z1, int id);
      box_cmd_type c;
      c.action = action;
      c.slot = bobs_pkg::SLOT_BITS'(slot);
      c.lo[0] = bobs_pkg::FIELD_BITS'(x0);
      c.lo[1] = bobs_pkg::FIELD_BITS'(y0);
      c.lo[2] = bobs_pkg::FIELD_BITS'(z0);
      c.hi[0] = bobs_pkg::FIELD_BITS'(x1);
      c.hi[1] = bobs_pkg::FIELD_BITS'(y1);
      c.hi[2] = bobs_pkg::FIELD_BITS'(z1);
      c.probe_id = bobs_pkg::ID_BITS'(id);
      return c;
   endfunction

   task automatic enqueue_cmd(box_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // per axis: mostly clustered boxes so that overlaps are common, plus
   // flat, inverted, full-range and extreme extents
   task automatic make_box(output logic [2:0][bobs_pkg::FIELD_BITS-1:0] lo,
                           output logic [2:0][bobs_pkg::FIELD_BITS-1:0] hi);
      int a, mode, c, h, grid, v0, v1, t;
      grid = ($urandom_range(0, 3) == 0) ? 256 : 1;
      for (a = 0; a < 3; a++) begin
         mode = $urandom_range(0, 99);
         c = (int'($urandom_range(0, 4095)) - 2048) / grid * grid;
         h = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, 1024)) / grid * grid;
         v0 = clamp_coord(c - h);
         v1 = clamp_coord(c + h);
         if (mode >= 65 && mode < 75) begin
            v0 = int'($urandom_range(0, 65535)) - 32768;
            v1 = int'($urandom_range(0, 65535)) - 32768;
         end else if (mode >= 75 && mode < 85) begin
            t = v0;
            v0 = v1 + 1;
            v1 = t;
         end else if (mode >= 85) begin
            case ($urandom_range(0, 3))
               0: v0 = -32768;
               1: v0 = 32767;
               2: v0 = -1;
               default: v0 = 0;
            endcase
            case ($urandom_range(0, 3))
               0: v1 = 32767;
               1: v1 = -32768;
               2: v1 = 1;
               default: v1 = v0;
            endcase
         end
         lo[a] = bobs_pkg::FIELD_BITS'(v0);
         hi[a] = bobs_pkg::FIELD_BITS'(v1);
      end
   endtask

   function automatic int pick_count();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return bobs_pkg::MAX_PROBES;
         3: return $urandom_range(bobs_pkg::MAX_PROBES + 1, 31);
         default: return $urandom_range(2, bobs_pkg::MAX_PROBES);
      endcase
   endfunction

   function automatic void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
   endfunction

   // block idle: nothing queued or on the bus, nothing outstanding
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || cmds_accepted != cmds_offered || req_bus.valid ||
             expected_picks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(int v);
      wait_drained();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = bobs_pkg::CSR_BITS'(v);
      probe_count_model = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic push_random(int load_pct);
      box_cmd_type c;
      make_box(c.lo, c.hi);
      c.action = ($urandom_range(0, 99) < load_pct) ? bobs_pkg::ACT_LOAD : bobs_pkg::ACT_QUERY;
      c.slot = bobs_pkg::SLOT_BITS'($urandom_range(0, bobs_pkg::MAX_PROBES - 1));
      c.probe_id = bobs_pkg::ID_BITS'($urandom_range(0, 255));
      enqueue_cmd(c);
   endtask

   // request driver
   always @(negedge clock) begin
      box_cmd_type c;
      if (!reset) begin
         if (req_bus.valid && cmds_accepted == cmds_offered && idle_on &&
             $urandom_range(0, 5) == 0)
            req_gap_left = $urandom_range(1, 6);
         if (req_bus.valid && cmds_accepted != cmds_offered) begin
            // still waiting for the transaction to be taken
         end else if (req_gap_left > 0) begin
            req_bus.valid <= 1'b0;
            req_gap_left--;
         end else if (pending_cmds.size() != 0) begin
            c = pending_cmds.pop_front();
            req_bus.action   <= c.action;
            req_bus.slot     <= c.slot;
            req_bus.min_x    <= c.lo[0];
            req_bus.min_y    <= c.lo[1];
            req_bus.min_z    <= c.lo[2];
            req_bus.max_x    <= c.hi[0];
            req_bus.max_y    <= c.hi[1];
            req_bus.max_z    <= c.hi[2];
            req_bus.probe_id <= c.probe_id;
            req_bus.valid    <= 1'b1;
            cmds_offered++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready: random stall bursts, plus the occasional long hold
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            long_hold_left--;
         end else if (long_holds_served < long_holds_asked) begin
            rsp_bus.ready <= 1'b0;
            long_hold_left = LONG_HOLD_CYCLES;
            long_holds_served++;
         end else if (rsp_stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_left = $urandom_range(0, 5);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // result check first, then the accepted transaction updates the shadow
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_picks.size() == 0) begin
               report("unexpected result, best_id", 64'hx, 64'(rsp_bus.best_id));
            end else begin
               want = expected_picks.pop_front();
               if (rsp_bus.found !== want.found)
                  report("found", 64'(want.found), 64'(rsp_bus.found));
               if (rsp_bus.keep_previous !== want.keep_previous)
                  report("keep_previous", 64'(want.keep_previous), 64'(rsp_bus.keep_previous));
               if (rsp_bus.best_id !== want.best_id)
                  report("best_id", 64'(want.best_id), 64'(rsp_bus.best_id));
               if (rsp_bus.best_volume !== want.best_volume)
                  report("best_volume", 64'(want.best_volume), 64'(rsp_bus.best_volume));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.action = req_bus.action;
            taken.slot = req_bus.slot;
            taken.lo = {req_bus.min_z, req_bus.min_y, req_bus.min_x};
            taken.hi = {req_bus.max_z, req_bus.max_y, req_bus.max_x};
            taken.probe_id = req_bus.probe_id;
            if (taken.action == bobs_pkg::ACT_LOAD) begin
               probe_lo[taken.slot] = taken.lo;
               probe_hi[taken.slot] = taken.hi;
               probe_tag[taken.slot] = taken.probe_id;
            end else begin
               expected_picks.insert(expected_picks.size(), pick_best_probe(taken));
            end
            cmds_accepted <= cmds_accepted + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int i, n, cnt, total, phase_no, load_pct;
      bit pause_mid;
      box_cmd_type c;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.action = bobs_pkg::ACT_LOAD;
      req_bus.slot = '0;
      req_bus.min_x = '0;
      req_bus.min_y = '0;
      req_bus.min_z = '0;
      req_bus.max_x = '0;
      req_bus.max_y = '0;
      req_bus.max_z = '0;
      req_bus.probe_id = '0;
      rsp_bus.ready = 1'b0;
      cmds_offered = 0;
      cmds_accepted = 0;
      errors = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      req_gap_left = 0;
      rsp_stall_left = 0;
      long_hold_left = 0;
      long_holds_asked = 0;
      long_holds_served = 0;
      probe_count_model = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, then fill every slot with corner cases and random boxes
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, -32768, -32768, -32768, 32767, 32767,
                         32767, 0));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_LOAD, 0, -32768, -32768, -32768, 32767, 32767,
                         32767, 255));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_LOAD, 1, 0, 0, 0, 0, 0, 0, 1));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_LOAD, 2, 100, -50, -50, -100, 50, 50, 2));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_LOAD, 3, -32768, -32768, -32768, 32767, 32767,
                         32767, 3));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_LOAD, 4, -32768, -32768, -32768, -32768, -32768,
                         -32768, 128));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_LOAD, 5, 32767, 32767, 32767, 32767, 32767,
                         32767, 127));
      for (i = 6; i < bobs_pkg::MAX_PROBES; i++) begin
         make_box(c.lo, c.hi);
         c.action = bobs_pkg::ACT_LOAD;
         c.slot = bobs_pkg::SLOT_BITS'(i);
         c.probe_id = bobs_pkg::ID_BITS'($urandom_range(0, 255));
         enqueue_cmd(c);
      end

      write_count(1);
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 15, -5, -5, -5, 5, 5, 5, 255));

      write_count(bobs_pkg::MAX_PROBES);
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, -32768, -32768, -32768, 32767, 32767,
                         32767, 0));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, -32768, -32768, -32768, -32768, -32768,
                         -32768, 0));
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, 10, 10, 10, -10, -10, -10, 0));

      // count above the table saturates
      write_count(31);
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, -200, -200, -200, 300, 300, 300, 0));

      write_count(2);
      enqueue_cmd(mk_cmd(bobs_pkg::ACT_QUERY, 0, -32768, -32768, -32768, 32767, 32767,
                         32767, 0));

      total = 0;
      phase_no = 0;
      while (total < RANDOM_ITEMS) begin
         cnt = pick_count();
         n = $urandom_range(30, 70);
         load_pct = 25;
         pause_mid = (phase_no == 3) || ($urandom_range(0, 7) == 0);
         write_count(phase_no == 2 ? bobs_pkg::MAX_PROBES : cnt);
         idle_on = (total >= RANDOM_ITEMS - 250) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (phase_no == 2) begin
            // long receiver hold while queries keep coming: input must back up
            load_pct = 5;
            long_holds_asked++;
         end
         for (i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) wait_drained();
            push_random(load_pct);
         end
         total += n;
         phase_no++;
      end

      wait_drained();
      if (errors == 0 && expected_picks.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
